// ----- design/ffa_pkg.sv -----
// shared constants, codes and controller/datapath interface types of the allocator
package ffa_pkg;

    localparam int HEAP_GRANULES = 4096;
    localparam int GRANULE_BYTES = 16;
    localparam int HEADER_BYTES  = 4;

    localparam int ADDR_W     = 32;
    localparam int REQ_W      = 16;
    localparam int LIMIT_W    = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int GIDX_W     = $clog2(HEAP_GRANULES);
    localparam int LINK_W     = GIDX_W + 1;
    localparam int GSH        = $clog2(GRANULE_BYTES);
    localparam int HEAP_BYTES = HEAP_GRANULES * GRANULE_BYTES;
    localparam int OFF_W      = $clog2(HEAP_BYTES) + 1;
    localparam int NEED_W     = REQ_W + 1 - GSH;
    localparam int BYTES_W    = NEED_W + GSH;
    localparam int SUM_W      = ((OFF_W > BYTES_W) ? OFF_W : BYTES_W) + 1;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_EVAL,
        S_CARVE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic do_free;
        logic start_walk;
        logic advance;
        logic unlink;
        logic carve;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic walk_end;
        logic fit;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/first_fit_free_list_allocator.sv -----
// top level of the first-fit free-list heap allocator
// One request at a time. A free holds the block through the idle, decode and finish
// states, from the cycle its request beat is accepted through the cycle that loads its
// result beat, which is offered on the next cycle. An allocate holds it through idle,
// decode and finish plus a walk and an eval state for every free-list entry it examines
// (walk reads the size and link memories at the current block, eval compares the stored
// size and follows the link); a walk that sees the end of the list goes on to a carve
// state before finish. The finish state repeats while the output register still holds
// an unaccepted beat. The walk gives up after 4096 links (a double free can loop the
// list). A new request is taken while the previous result beat still waits at the
// output; its result waits in turn until the output register frees up. The user must
// write heap base and limit through the config port only while the block is idle; the
// block itself does not enforce this. The size and link memories are not cleared at
// reset, which is safe because only carved granules are ever read back by legal
// traffic.
module first_fit_free_list_allocator import ffa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // request beat
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [REQ_W-1:0]     i_request_bytes,
    input  logic [ADDR_W-1:0]    i_user_address,
    // result beat
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_W-1:0]    o_result_address,
    output logic [1:0]           o_status
);

    // command and status between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    ffa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_request_bytes  (i_request_bytes),
        .i_user_address   (i_user_address),
        .i_out_ready      (i_out_ready),
        .i_dp_cmd         (dp_cmd),
        .o_sts            (dp_sts),
        .o_out_valid      (o_out_valid),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

endmodule

// ----- design/ffa_ctrl.sv -----
// sequencer for decode, free-list walk, carve and result hand-off
module ffa_ctrl import ffa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_sts.is_free ? S_FINISH : S_WALK;
            end
            S_WALK: begin
                n_state = i_sts.walk_end ? S_CARVE : S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.fit ? S_FINISH : S_WALK;
            end
            S_CARVE: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.do_free    = i_sts.is_free;
                o_cmd.start_walk = !i_sts.is_free;
            end
            S_WALK: begin
            end
            S_EVAL: begin
                o_cmd.unlink  = i_sts.fit;
                o_cmd.advance = !i_sts.fit;
            end
            S_CARVE: begin
                o_cmd.carve = 1'b1;
            end
            S_FINISH: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- design/ffa_dp.sv -----
// datapath: config, heap state, size and link memories, result registers
module ffa_dp import ffa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_cmd,
    input  logic [REQ_W-1:0]     i_request_bytes,
    input  logic [ADDR_W-1:0]    i_user_address,
    input  logic                 i_out_ready,
    input  t_dp_cmd              i_dp_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    output logic [ADDR_W-1:0]    o_result_address,
    output logic [1:0]           o_status
);

    logic [ADDR_W-1:0]  r_heap_base;
    logic [LIMIT_W-1:0] r_heap_limit;

    t_cmd               r_cmd;
    logic [NEED_W-1:0]  r_need;
    logic [ADDR_W-1:0]  r_off;

    logic [LINK_W-1:0]  r_head;
    logic [OFF_W-1:0]   r_break;
    logic [LINK_W-1:0]  r_cur;
    logic [LINK_W-1:0]  r_prev;
    logic [LINK_W-1:0]  r_steps;

    logic [NEED_W-1:0]  r_mem_bg [HEAP_GRANULES];
    logic [LINK_W-1:0]  r_mem_nl [HEAP_GRANULES];
    logic [NEED_W-1:0]  r_rd_bg;
    logic [LINK_W-1:0]  r_rd_nl;

    logic [ADDR_W-1:0]  r_res_addr;
    t_status            r_res_status;
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    t_status            r_out_status;

    logic [REQ_W:0]     req_sum;
    logic [NEED_W-1:0]  need;
    logic               free_ok;
    logic [GIDX_W-1:0]  free_g;
    logic [LIMIT_W-1:0] limit_eff;
    logic [BYTES_W-1:0] carve_bytes;
    logic [SUM_W-1:0]   carve_sum;
    logic               carve_ok;
    logic [GIDX_W-1:0]  carve_g;
    logic [GIDX_W-1:0]  cur_idx;
    logic [GIDX_W-1:0]  prev_idx;
    logic               prev_none;
    logic [GIDX_W-1:0]  addr_idx;
    logic [ADDR_W-1:0]  user_addr;
    logic               bg_we;
    logic               nl_we;
    logic [GIDX_W-1:0]  nl_waddr;
    logic [LINK_W-1:0]  nl_wdata;

    // granules needed: header added, rounded up to a granule
    assign req_sum = {1'b0, i_request_bytes} + (REQ_W+1)'(HEADER_BYTES + GRANULE_BYTES - 1);
    assign need    = req_sum[REQ_W:GSH];

    assign free_ok = (ADDR_W'(r_break) > r_off) && (r_off[GSH-1:0] == '0);
    assign free_g  = r_off[GSH +: GIDX_W];

    assign limit_eff   = (r_heap_limit > LIMIT_W'(HEAP_BYTES)) ? LIMIT_W'(HEAP_BYTES)
                                                               : r_heap_limit;
    assign carve_bytes = {r_need, {GSH{1'b0}}};
    assign carve_sum   = SUM_W'(r_break) + SUM_W'(carve_bytes);
    assign carve_ok    = (carve_sum <= SUM_W'(limit_eff)) && !r_break[OFF_W-1];
    assign carve_g     = r_break[GSH +: GIDX_W];

    assign cur_idx   = r_cur[GIDX_W-1:0];
    assign prev_idx  = r_prev[GIDX_W-1:0];
    assign prev_none = r_prev[LINK_W-1];

    assign addr_idx  = i_dp_cmd.carve ? carve_g : cur_idx;
    assign user_addr = r_heap_base + ADDR_W'({addr_idx, {GSH{1'b0}}})
                     + ADDR_W'(HEADER_BYTES);

    assign bg_we    = i_dp_cmd.carve && carve_ok;
    assign nl_we    = (i_dp_cmd.do_free && free_ok) || (i_dp_cmd.unlink && !prev_none);
    assign nl_waddr = i_dp_cmd.do_free ? free_g : prev_idx;
    assign nl_wdata = i_dp_cmd.do_free ? r_head : r_rd_nl;

    assign o_sts.is_free  = (r_cmd == CMD_FREE);
    assign o_sts.walk_end = r_cur[LINK_W-1] || r_steps[LINK_W-1];
    assign o_sts.fit      = (r_rd_bg >= r_need);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= LIMIT_W'(HEAP_BYTES);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // heap control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= LINK_W'(HEAP_GRANULES);
            r_break     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dp_cmd.do_free && free_ok) begin
                r_head <= {1'b0, free_g};
            end else if (i_dp_cmd.unlink && prev_none) begin
                r_head <= r_rd_nl;
            end
            if (bg_we) begin
                r_break <= carve_sum[OFF_W-1:0];
            end
            if (i_dp_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, walk pointers and results
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_need <= need;
            r_off  <= i_user_address - r_heap_base - ADDR_W'(HEADER_BYTES);
        end
        if (i_dp_cmd.start_walk) begin
            r_cur   <= r_head;
            r_prev  <= LINK_W'(HEAP_GRANULES);
            r_steps <= '0;
        end else if (i_dp_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_nl;
            r_steps <= r_steps + LINK_W'(1);
        end
        if (i_dp_cmd.do_free) begin
            r_res_addr   <= '0;
            r_res_status <= free_ok ? ST_OK : ST_BAD_FREE;
        end else if (i_dp_cmd.unlink) begin
            r_res_addr   <= user_addr;
            r_res_status <= ST_OK;
        end else if (i_dp_cmd.carve) begin
            r_res_addr   <= carve_ok ? user_addr : '0;
            r_res_status <= carve_ok ? ST_OK : ST_OOM;
        end
        if (i_dp_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    // block size memory
    always_ff @(posedge i_clk) begin
        if (bg_we) begin
            r_mem_bg[carve_g] <= r_need;
        end
        r_rd_bg <= r_mem_bg[cur_idx];
    end

    // free-list link memory
    always_ff @(posedge i_clk) begin
        if (nl_we) begin
            r_mem_nl[nl_waddr] <= nl_wdata;
        end
        r_rd_nl <= r_mem_nl[cur_idx];
    end

endmodule

// ----- design/ffa_chk.sv -----
// port-level checks of the allocator and their bind
module ffa_chk import ffa_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [ADDR_W-1:0]    i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_cmd,
    input logic [REQ_W-1:0]     i_request_bytes,
    input logic [ADDR_W-1:0]    i_user_address,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [ADDR_W-1:0]    o_result_address,
    input logic [1:0]           o_status
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat offered after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_address) && $stable(o_status))
        else $error("stalled result beat changed");

    // one request in flight: ready drops after a request beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one in flight");

    // only known status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK) || (o_status == ST_OOM)
                        || (o_status == ST_BAD_FREE))
        else $error("unknown status code");

    // failed requests carry a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_result_address == '0)
        else $error("failed request returned an address");

endmodule

bind first_fit_free_list_allocator ffa_chk u_ffa_chk (.*);
